[rtl/core/button_press_pattern_classifier_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef BUTTON_PRESS_PATTERN_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_PATTERN_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define BPPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bppc check failed: same-cycle rule");

// Next-cycle implication, quiet while reset is high.
`define BPPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bppc check failed: next-cycle rule");

`endif

[rtl/core/bppc_pkg.sv]
package bppc_pkg;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_SET_ON     = 3'd1,
    ACT_SET_OFF    = 3'd2,
    ACT_REMOTE_EN  = 3'd3,
    ACT_REMOTE_DIS = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    CFG_PRESS_LEVEL   = 3'd0,
    CFG_SHORT_MIN_MS  = 3'd1,
    CFG_LONG_MIN_MS   = 3'd2,
    CFG_IDLE_RESET_MS = 3'd3,
    CFG_HOLD_LIMIT_MS = 3'd4,
    CFG_SHUTDOWN_EN   = 3'd5
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  RST_PRESS_LEVEL   = 8'd128;
  localparam logic [15:0] RST_SHORT_MIN_MS  = 16'd25;
  localparam logic [15:0] RST_LONG_MIN_MS   = 16'd500;
  localparam logic [15:0] RST_IDLE_RESET_MS = 16'd2000;
  localparam logic [16:0] RST_HOLD_LIMIT_MS = 17'd120000;

  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam int unsigned SHUTDOWN_LONGS = 3;

  typedef struct packed {
    logic [7:0]  press_level;
    logic [15:0] short_min_ms;
    logic [15:0] long_min_ms;
    logic [15:0] idle_reset_ms;
    logic [16:0] hold_limit_ms;
    logic        shutdown_enable;
  } cfg_t;

  // Classified tick handed from front to back.
  typedef struct packed {
    logic        pressed;
    logic [7:0]  level;
    logic [15:0] elapsed_ms;
  } tick_t;

endpackage

[rtl/core/bppc_front.sv]
module bppc_front (
  input  logic                clk,
  input  logic                rst,
  input  bppc_pkg::cfg_t      cfg,
  input  logic                take,
  input  logic [2:0]          action,
  input  logic [7:0]          touch_level,
  input  logic [7:0]          set_level,
  input  logic [15:0]         elapsed_ms,
  output bppc_pkg::tick_t     tick
);

  logic       remote_on;
  logic       remote_on_next;
  logic [7:0] below;
  logic [7:0] val;
  logic [7:0] level;

  always_comb begin
    below = (cfg.press_level == 8'd0) ? 8'd0 : cfg.press_level - 8'd1;
    remote_on_next = remote_on;
    val = 8'd0;
    case (action)
      bppc_pkg::ACT_SET_ON: begin
        val = (set_level > cfg.press_level) ? set_level : cfg.press_level;
      end
      bppc_pkg::ACT_SET_OFF: begin
        val = (set_level < below) ? set_level : below;
      end
      bppc_pkg::ACT_REMOTE_EN: begin
        val = bppc_pkg::LEVEL_FULL;
        remote_on_next = 1'b1;
      end
      bppc_pkg::ACT_REMOTE_DIS: begin
        val = 8'd0;
        remote_on_next = 1'b0;
      end
      default: begin
        val = 8'd0;
      end
    endcase
    if (remote_on_next) begin
      val = bppc_pkg::LEVEL_FULL;
    end
    level = (val > touch_level) ? val : touch_level;
    tick.pressed = (level >= cfg.press_level);
    tick.level = level;
    tick.elapsed_ms = elapsed_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_on <= 1'b0;
    end else if (take) begin
      remote_on <= remote_on_next;
    end
  end

endmodule

[rtl/core/bppc_queue.sv]
module bppc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bppc_pkg::tick_t   push_data,
  input  logic              pop,
  output bppc_pkg::tick_t   pop_data,
  output logic              full,
  output logic              empty
);

  bppc_pkg::tick_t mem [bppc_pkg::QUEUE_DEPTH];
  logic [bppc_pkg::QPTR_W-1:0] wr_ptr;
  logic [bppc_pkg::QPTR_W-1:0] rd_ptr;
  logic [bppc_pkg::QCNT_W-1:0] count;

  assign full = (count == bppc_pkg::QCNT_W'(bppc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bppc_pkg::QPTR_W'(bppc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bppc_pkg::QPTR_W'(bppc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/bppc_back.sv]
module bppc_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bppc_pkg::cfg_t    cfg,
  input  logic              avail,
  input  bppc_pkg::tick_t   tick,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [79:0]       out_data
);

  logic signed [17:0]      hold_time;
  logic [COUNT_WIDTH-1:0]  presses;
  logic [COUNT_WIDTH-1:0]  shorts;
  logic [COUNT_WIDTH-1:0]  longs;
  logic [COUNT_WIDTH-1:0]  last_shutdown_presses;

  logic signed [18:0]      hold_ext;
  logic signed [18:0]      el_ext;
  logic signed [18:0]      lim_ext;
  logic signed [18:0]      hold_sum;
  logic signed [17:0]      hold_time_next;
  logic [COUNT_WIDTH-1:0]  presses_next;
  logic [COUNT_WIDTH-1:0]  shorts_next;
  logic [COUNT_WIDTH-1:0]  longs_next;
  logic                    srel;
  logic                    lrel;
  logic                    shut;
  logic [COUNT_WIDTH+15:0] presses_wide;
  logic [COUNT_WIDTH+15:0] shorts_wide;
  logic [COUNT_WIDTH+15:0] longs_wide;

  assign pop = avail && (!out_valid || out_ready);

  always_comb begin
    hold_ext = 19'(hold_time);
    el_ext = signed'({3'b000, tick.elapsed_ms});
    lim_ext = signed'({2'b00, cfg.hold_limit_ms});
    presses_next = presses;
    shorts_next = shorts;
    longs_next = longs;
    srel = 1'b0;
    lrel = 1'b0;
    if (!tick.pressed) begin
      if (hold_ext > signed'({3'b000, cfg.short_min_ms})) begin
        presses_next = presses + 1'b1;
        if (hold_ext > signed'({3'b000, cfg.long_min_ms})) begin
          longs_next = longs + 1'b1;
          lrel = 1'b1;
        end else begin
          shorts_next = shorts + 1'b1;
          srel = 1'b1;
        end
      end else if (hold_ext < -signed'({3'b000, cfg.idle_reset_ms})) begin
        shorts_next = '0;
        longs_next = '0;
      end
      hold_sum = (hold_ext < 0) ? hold_ext - el_ext : -el_ext;
    end else begin
      hold_sum = (hold_ext > 0) ? hold_ext + el_ext : el_ext;
    end
    // Saturate at the hold limit in both directions.
    if (hold_sum < -lim_ext) begin
      hold_time_next = 18'(-lim_ext);
    end else if (hold_sum > lim_ext) begin
      hold_time_next = 18'(lim_ext);
    end else begin
      hold_time_next = 18'(hold_sum);
    end
    shut = cfg.shutdown_enable
        && (longs_next == COUNT_WIDTH'(bppc_pkg::SHUTDOWN_LONGS))
        && (presses_next != last_shutdown_presses);
    presses_wide = {16'd0, presses_next};
    shorts_wide = {16'd0, shorts_next};
    longs_wide = {16'd0, longs_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= '0;
      presses <= '0;
      shorts <= '0;
      longs <= '0;
      last_shutdown_presses <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        hold_time <= hold_time_next;
        presses <= presses_next;
        shorts <= shorts_next;
        longs <= longs_next;
        if (shut) begin
          last_shutdown_presses <= presses_next;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {2'b00, shut, lrel, srel, longs_wide[15:0], shorts_wide[15:0],
                   presses_wide[15:0], hold_time_next, tick.level, tick.pressed};
    end
  end

endmodule

[rtl/core/button_press_pattern_classifier_core.sv]
// Channel  | Dir | Signals                          | Content
// s        | in  | s_tvalid s_tready s_tdata s_tuser | one tick per transfer
// m        | out | m_tvalid m_tready m_tdata        | one result per tick
// cfg      | in  | cfg_we cfg_index cfg_data        | register writes, no read-back
//
// Sustained rate is one tick per cycle while m_tready stays high; a result passes from its input
// transfer through a queue entry and then the output register before it shows on m.
// The front stage classifies a tick in the cycle it is taken; the back stage
// updates hold time and counters as it pops each tick from the queue.
// A two-entry queue lets the input keep taking ticks while a result is stalled.
// Reset (rst, synchronous) clears the queue, counters, hold time and remote flag.
module button_press_pattern_classifier_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] touch_level, [15:8] set_level, [31:16] elapsed_ms
  input  logic [31:0] s_tdata,
  // [2:0] action
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] pressed, [8:1] level, [26:9] held_ms, [42:27] press_count,
  // [58:43] short_count, [74:59] long_count, [75] short_release,
  // [76] long_release, [77] shutdown_request, [79:78] zero
  output logic [79:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [bppc_pkg::CFG_DATA_W-1:0] cfg_data
);

  bppc_pkg::cfg_t  cfg;
  bppc_pkg::tick_t front_tick;
  bppc_pkg::tick_t back_tick;
  logic            take;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  assign s_tready = !q_full;
  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level <= bppc_pkg::RST_PRESS_LEVEL;
      cfg.short_min_ms <= bppc_pkg::RST_SHORT_MIN_MS;
      cfg.long_min_ms <= bppc_pkg::RST_LONG_MIN_MS;
      cfg.idle_reset_ms <= bppc_pkg::RST_IDLE_RESET_MS;
      cfg.hold_limit_ms <= bppc_pkg::RST_HOLD_LIMIT_MS;
      cfg.shutdown_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bppc_pkg::CFG_PRESS_LEVEL:   cfg.press_level <= cfg_data[7:0];
        bppc_pkg::CFG_SHORT_MIN_MS:  cfg.short_min_ms <= cfg_data[15:0];
        bppc_pkg::CFG_LONG_MIN_MS:   cfg.long_min_ms <= cfg_data[15:0];
        bppc_pkg::CFG_IDLE_RESET_MS: cfg.idle_reset_ms <= cfg_data[15:0];
        bppc_pkg::CFG_HOLD_LIMIT_MS: cfg.hold_limit_ms <= cfg_data[16:0];
        bppc_pkg::CFG_SHUTDOWN_EN:   cfg.shutdown_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bppc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .action      (s_tuser),
    .touch_level (s_tdata[7:0]),
    .set_level   (s_tdata[15:8]),
    .elapsed_ms  (s_tdata[31:16]),
    .tick        (front_tick)
  );

  bppc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (front_tick),
    .pop       (q_pop),
    .pop_data  (back_tick),
    .full      (q_full),
    .empty     (q_empty)
  );

  bppc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .avail     (!q_empty),
    .tick      (back_tick),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

[rtl/core/bppc_checker.sv]
`include "button_press_pattern_classifier_core_macros.svh"

module bppc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  // Stalled result holds.
  `BPPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Input only backs up behind a pending result.
  `BPPC_ASSERT_NOW(a_stall_needs_result, s_tvalid && !s_tready, m_tvalid)

  // A release pulse is never both short and long.
  `BPPC_ASSERT_NOW(a_one_release, m_tvalid, !(m_tdata[75] && m_tdata[76]))

  // A pressed tick cannot end a press.
  `BPPC_ASSERT_NOW(a_pressed_no_release, m_tvalid && m_tdata[0], !m_tdata[75] && !m_tdata[76])

  // Shutdown only fires with the long count at three.
  `BPPC_ASSERT_NOW(a_shutdown_longs, m_tvalid && m_tdata[77], m_tdata[74:59] == 16'd3)

endmodule

bind button_press_pattern_classifier_core bppc_checker u_bppc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
